// ===== rtl/pesd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Pixel event stream decoder package
// Shared widths, codes and types for the readout word decoder.
// ----------------------------------------------------------------------------
package pesd_pkg;

   localparam int WORD_W      = 16;
   localparam int PAYLOAD_W   = 12;
   localparam int RAW_W       = 2 * PAYLOAD_W;
   localparam int INDEX_W     = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 1;
   localparam int HDR_BIT     = 15;
   localparam int END_BIT     = 14;

   localparam logic [WORD_W-1:0]  HDR_MASK  = 16'h8ffc;
   localparam logic [WORD_W-1:0]  HDR_MATCH = 16'h87f8;
   localparam logic [INDEX_W-1:0] INDEX_MAX = 13'd4160;

   localparam logic [CSR_INDEX_W-1:0] CSR_LINEAR_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT_ADDRESS = 2'd1;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      PH_SEEK      = 2'd0,
      PH_AFTER_HDR = 2'd1,
      PH_FIRST     = 2'd2,
      PH_SECOND    = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HIT        = 2'd0,
      KIND_EMPTY      = 2'd1,
      KIND_INCOMPLETE = 2'd2
   } kind_type;

   typedef struct packed {
      logic linear_address;
      logic invert_address;
   } cfg_type;

   typedef struct packed {
      logic [7:0] pulse_height;
      logic [6:0] column;
      logic [7:0] row;
   } hit_fields_type;

   typedef struct packed {
      kind_type                kind;
      logic [PAYLOAD_W-1:0]    header_bits;
      hit_fields_type          hit;
      logic [INDEX_W-1:0]      pixel_index;
      logic                    event_end;
      logic                    trailing_error;
   } result_entry_type;

   typedef struct packed {
      kind_type                kind;
      logic [PAYLOAD_W-1:0]    header_bits;
      hit_fields_type          hit;
      logic [INDEX_W-1:0]      pixel_index;
      logic                    event_end;
      logic                    last_of_step;
   } rsp_beat_type;

   typedef struct packed {
      logic       full;
      logic [1:0] level;
   } queue_status_type;

endpackage
`default_nettype wire

// ===== rtl/pixel_event_stream_decoder_unit.sv =====
// Path: a taken word is held in the input register, decoded from there, and its
//   result is written into the result queue, from which the output is driven.
// Throughput: one word per cycle through the input register and two-entry
//   result queue while the queue is not full; a hit with an error leaves as two beats.
// Reset: synchronous, clears phase, header, pair half, hit count, queue and
//   both address mode registers.
`default_nettype none
// ----------------------------------------------------------------------------
// Pixel event stream decoder
// Finds chip headers in readout words, pairs data words into hit records and
// reports hits, empty events and incomplete data.
// ----------------------------------------------------------------------------
module pixel_event_stream_decoder_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [pesd_pkg::WORD_W-1:0]      req_word,
   input  wire logic                             req_end_of_buffer,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [1:0]                            rsp_kind,
   output logic [pesd_pkg::PAYLOAD_W-1:0]        rsp_header_bits,
   output logic [7:0]                            rsp_pulse_height,
   output logic [6:0]                            rsp_column,
   output logic signed [7:0]                     rsp_row,
   output logic [pesd_pkg::INDEX_W-1:0]          rsp_pixel_index,
   output logic                                  rsp_event_end,
   output logic                                  rsp_last_of_step,
   input  wire logic                             csr_write_enable,
   input  wire logic [pesd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pesd_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import pesd_pkg::*;

   cfg_type          cfg_ff;
   cfg_type          cfg_in;
   logic             in_valid_ff;
   logic             in_valid_in;
   logic [WORD_W-1:0] in_word_ff;
   logic             in_eob_ff;

   logic             req_fire;
   logic             step;
   logic             push;
   result_entry_type entry;
   rsp_beat_type     beat;
   queue_status_type q_status;

   assign req_fire  = req_valid && req_ready;
   assign step      = in_valid_ff && !q_status.full;
   assign req_ready = !in_valid_ff || !q_status.full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LINEAR_ADDRESS: cfg_in.linear_address = csr_write_data[0];
            CSR_INVERT_ADDRESS: cfg_in.invert_address = csr_write_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= '0;
         in_valid_ff <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_word_ff <= req_word;
         in_eob_ff  <= req_end_of_buffer;
      end
   end

   pesd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .word          (in_word_ff),
      .end_of_buffer (in_eob_ff),
      .cfg           (cfg_ff),
      .push          (push),
      .entry         (entry)
   );

   pesd_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .entry     (entry),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .beat      (beat),
      .status    (q_status)
   );

   assign rsp_kind         = beat.kind;
   assign rsp_header_bits  = beat.header_bits;
   assign rsp_pulse_height = beat.hit.pulse_height;
   assign rsp_column       = beat.hit.column;
   assign rsp_row          = beat.hit.row;
   assign rsp_pixel_index  = beat.pixel_index;
   assign rsp_event_end    = beat.event_end;
   assign rsp_last_of_step = beat.last_of_step;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (!in_valid_ff || step))
      else $error("input register overwritten before its word was decoded");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.level <= 2'(QUEUE_DEPTH))
      else $error("result queue level out of range");

   a_report_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_HIT) |-> rsp_last_of_step)
      else $error("empty or incomplete report not last of its word");

   a_trailing_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_kind == KIND_HIT && !rsp_last_of_step) |=>
      (rsp_valid && rsp_kind == KIND_INCOMPLETE && rsp_last_of_step))
      else $error("hit not followed by its incomplete-data report");
`endif

endmodule
`default_nettype wire

// ===== rtl/pesd_hit_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hit record decoder
// Turns a 24-bit hit record into pulse height, column and row, using either
// linear address fields or the base-6 coded double column and row.
// ----------------------------------------------------------------------------
module pesd_hit_decode (
   input  wire pesd_pkg::cfg_type          cfg,
   input  wire logic [pesd_pkg::RAW_W-1:0] raw,
   output pesd_pkg::hit_fields_type        hit
);
   import pesd_pkg::*;

   logic [14:0] addr;
   logic [2:0]  r2;
   logic [2:0]  r1;
   logic [2:0]  r0;
   logic [5:0]  dcol;
   logic [8:0]  rcode;
   logic [8:0]  row_diff;
   logic [7:0]  coded_row;
   logic [6:0]  coded_col;
   logic [7:0]  linear_row;
   logic [6:0]  linear_col;

   assign addr = raw[RAW_W-1:9];

   always_comb begin
      r2 = addr[8:6] ^ {3{cfg.invert_address}};
      r1 = addr[5:3] ^ {3{cfg.invert_address}};
      r0 = addr[2:0] ^ {3{cfg.invert_address}};
      dcol  = 6'(addr[14:12]) * 6'd6 + 6'(addr[11:9]);
      rcode = 9'(r2) * 9'd36 + 9'(r1) * 9'd6 + 9'(r0);
      // row counts down from 80 in half steps, wrapping negative
      row_diff  = 9'd80 - {1'b0, rcode[8:1]};
      coded_row = row_diff[7:0];
      coded_col = {dcol, rcode[0]};
      linear_row = {1'b0, addr[7:4], addr[2:0]};
      linear_col = {1'b0, addr[14:12], addr[10:8]};
   end

   always_comb begin
      hit.pulse_height = {raw[8:5], raw[3:0]};
      if (cfg.linear_address) begin
         hit.column = linear_col;
         hit.row    = linear_row;
      end else begin
         hit.column = coded_col;
         hit.row    = coded_row;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/pesd_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Event framing control
// Tracks header, pair and end-of-event phases and builds one queue entry per
// readout word that yields a result.
// ----------------------------------------------------------------------------
module pesd_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,
   input  wire logic [pesd_pkg::WORD_W-1:0] word,
   input  wire logic                        end_of_buffer,
   input  wire pesd_pkg::cfg_type           cfg,
   output logic                             push,
   output pesd_pkg::result_entry_type       entry
);
   import pesd_pkg::*;

   phase_type            phase_ff;
   phase_type            phase_in;
   logic [PAYLOAD_W-1:0] header_ff;
   logic [PAYLOAD_W-1:0] header_in;
   logic [PAYLOAD_W-1:0] upper_ff;
   logic [PAYLOAD_W-1:0] upper_in;
   logic [INDEX_W-1:0]   count_ff;
   logic [INDEX_W-1:0]   count_in;

   logic           hdr_match;
   phase_type      hdr_phase;
   logic           hdr_bit;
   logic           end_bit;
   hit_fields_type hit;

   assign hdr_match = (word & HDR_MASK) == HDR_MATCH;
   assign hdr_phase = (hdr_match && !end_of_buffer) ? PH_AFTER_HDR : PH_SEEK;
   assign hdr_bit   = word[HDR_BIT];
   assign end_bit   = word[END_BIT];

   pesd_hit_decode u_hit_decode (
      .cfg (cfg),
      .raw ({upper_ff, word[PAYLOAD_W-1:0]}),
      .hit (hit)
   );

   // next state
   always_comb begin
      phase_in  = phase_ff;
      header_in = header_ff;
      upper_in  = upper_ff;
      count_in  = count_ff;
      if (step) begin
         unique case (phase_ff)
            PH_SEEK, PH_AFTER_HDR, PH_FIRST: begin
               if ((phase_ff == PH_SEEK) || (phase_ff == PH_AFTER_HDR && hdr_bit) ||
                   end_of_buffer || end_bit) begin
                  // re-examine the word as a header
                  phase_in = hdr_phase;
                  if (hdr_match) begin
                     header_in = word[PAYLOAD_W-1:0];
                     count_in  = '0;
                  end
               end else begin
                  upper_in = word[PAYLOAD_W-1:0];
                  phase_in = PH_SECOND;
               end
            end
            PH_SECOND: begin
               if (count_ff < INDEX_MAX) begin
                  count_in = count_ff + INDEX_W'(1);
               end
               phase_in = (end_bit || end_of_buffer) ? PH_SEEK : PH_FIRST;
            end
            default: phase_in = PH_SEEK;
         endcase
      end
   end

   // outputs
   always_comb begin
      push                 = 1'b0;
      entry.kind           = KIND_HIT;
      entry.header_bits    = header_ff;
      entry.hit            = '0;
      entry.pixel_index    = '0;
      entry.event_end      = 1'b0;
      entry.trailing_error = 1'b0;
      unique case (phase_ff)
         PH_SEEK: push = 1'b0;
         PH_AFTER_HDR, PH_FIRST: begin
            if (phase_ff == PH_AFTER_HDR && hdr_bit) begin
               push       = step;
               entry.kind = KIND_EMPTY;
            end else if (end_of_buffer || end_bit) begin
               push       = step;
               entry.kind = KIND_INCOMPLETE;
            end
         end
         PH_SECOND: begin
            push                 = step;
            entry.hit            = hit;
            entry.pixel_index    = count_ff;
            entry.event_end      = end_bit;
            entry.trailing_error = end_of_buffer && !end_bit;
         end
         default: push = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SEEK;
         header_ff <= '0;
         upper_ff  <= '0;
         count_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         header_ff <= header_in;
         upper_ff  <= upper_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/pesd_rsp_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Result queue
// Two-entry result buffer; an entry that carries a trailing error goes out
// as two beats, the hit first and the incomplete-data report after it.
// ----------------------------------------------------------------------------
module pesd_rsp_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire pesd_pkg::result_entry_type entry,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output pesd_pkg::rsp_beat_type          beat,
   output pesd_pkg::queue_status_type      status
);
   import pesd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   result_entry_type entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [1:0]       level_ff;
   logic [1:0]       level_in;
   logic             err_phase_ff;
   logic             err_phase_in;

   result_entry_type head;
   logic             take;
   logic             pop;

   assign head      = entries_ff[rd_ptr_ff];
   assign rsp_valid = level_ff != 2'd0;
   assign take      = rsp_valid && rsp_ready;
   assign pop       = take && (!head.trailing_error || err_phase_ff);

   assign status.full  = level_ff == 2'(QUEUE_DEPTH);
   assign status.level = level_ff;

   always_comb begin
      if (err_phase_ff) begin
         beat.kind         = KIND_INCOMPLETE;
         beat.header_bits  = head.header_bits;
         beat.hit          = '0;
         beat.pixel_index  = '0;
         beat.event_end    = 1'b0;
         beat.last_of_step = 1'b1;
      end else begin
         beat.kind         = head.kind;
         beat.header_bits  = head.header_bits;
         beat.hit          = head.hit;
         beat.pixel_index  = head.pixel_index;
         beat.event_end    = head.event_end;
         beat.last_of_step = !head.trailing_error;
      end
   end

   always_comb begin
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      err_phase_in = err_phase_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (take) begin
         // hold the entry for its error beat, else advance
         err_phase_in = !pop;
      end
      level_in = level_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         level_ff     <= '0;
         err_phase_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         level_ff     <= level_in;
         err_phase_ff <= err_phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule
`default_nettype wire
